// ----- hw/rtl/cfd_pkg.sv -----
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants for the command frame deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

   // parameter store depth and derived widths
   localparam int MAX_PARAMS   = 16;
   localparam int BYTE_W       = 8;
   localparam int PARAM_ADDR_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
   localparam int PARAM_CNT_W  = $clog2(MAX_PARAMS + 1);
   // emit step counts opcode, length and up to MAX_PARAMS parameters
   localparam int STEP_W       = $clog2(MAX_PARAMS + 2);

   typedef logic [BYTE_W-1:0] byte_type;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_OPCODE,
      PH_LENGTH,
      PH_PARAMS,
      PH_EMIT
   } phase_type;

endpackage

// ----- hw/rtl/command_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// command_frame_deframer
// Hunts for a prefix byte, collects opcode, length and parameter bytes into
// a parameter store, then replays the frame as a run of response bytes.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  ----------+-----------+-------------------------------------------------
//  req_*     | in        | rx_byte, one received byte per request
//  rsp_*     | out       | frame_byte, frame_last, too_long
//  csr_*     | in        | frame_prefix write, no read-back
//
//  Parsing takes one request per cycle while the response register is free.
//  A completed frame of length n is replayed as n + 2 response bytes from the
//  parameter store, a synchronous memory read one byte ahead of the
//  response register; no request is taken during the replay.
//  Reset clears the parser to hunting and the prefix to zero.
//  A stalled response holds its register and the replay sequencer.
// ----------------------------------------------------------------------------
module command_frame_deframer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cfd_pkg::byte_type    req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cfd_pkg::byte_type    rsp_frame_byte,
   output logic                 rsp_frame_last,
   output logic                 rsp_too_long,
   input  logic                 csr_wr_en,
   input  cfd_pkg::byte_type    csr_wr_data
);

   localparam int LEN_W = cfd_pkg::BYTE_W;

   cfd_pkg::phase_type phase_ff, phase_in;

   cfd_pkg::byte_type frame_prefix_ff;
   cfd_pkg::byte_type held_opcode_ff, held_opcode_in;
   cfd_pkg::byte_type held_length_ff, held_length_in;
   logic [cfd_pkg::PARAM_CNT_W-1:0] param_count_ff, param_count_in;
   logic [cfd_pkg::STEP_W-1:0]      step_ff, step_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   cfd_pkg::byte_type    rsp_frame_byte_ff, rsp_frame_byte_in;
   logic                 rsp_frame_last_ff, rsp_frame_last_in;
   logic                 rsp_too_long_ff, rsp_too_long_in;

   cfd_pkg::byte_type param_store [cfd_pkg::MAX_PARAMS];
   cfd_pkg::byte_type rd_data_ff;
   logic [cfd_pkg::PARAM_ADDR_W-1:0] rd_addr;
   logic                 wr_en;

   logic out_free;
   logic req_take;
   logic emit_load;
   logic too_long_len;
   logic params_done;
   logic emit_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (phase_ff != cfd_pkg::PH_EMIT) && out_free;
   assign req_take  = req_valid && req_ready;
   assign emit_load = (phase_ff == cfd_pkg::PH_EMIT) && out_free;

   assign too_long_len = req_rx_byte > LEN_W'(cfd_pkg::MAX_PARAMS);
   assign params_done  = (LEN_W'(param_count_ff) + LEN_W'(1)) == held_length_ff;
   assign emit_last    = LEN_W'(step_ff) == (held_length_ff + LEN_W'(1));

   assign wr_en = req_take && (phase_ff == cfd_pkg::PH_PARAMS);

   // read one parameter ahead of the step that will show it
   always_comb begin
      if (emit_load) begin
         rd_addr = cfd_pkg::PARAM_ADDR_W'(step_ff - cfd_pkg::STEP_W'(1));
      end else begin
         rd_addr = cfd_pkg::PARAM_ADDR_W'(step_ff - cfd_pkg::STEP_W'(2));
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         param_store[param_count_ff[cfd_pkg::PARAM_ADDR_W-1:0]] <= req_rx_byte;
      end
      rd_data_ff <= param_store[rd_addr];
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         cfd_pkg::PH_HUNT: begin
            if (req_take && (req_rx_byte == frame_prefix_ff)) begin
               phase_in = cfd_pkg::PH_OPCODE;
            end
         end
         cfd_pkg::PH_OPCODE: begin
            if (req_take) begin
               phase_in = cfd_pkg::PH_LENGTH;
            end
         end
         cfd_pkg::PH_LENGTH: begin
            if (req_take) begin
               priority if (too_long_len) begin
                  phase_in = cfd_pkg::PH_HUNT;
               end else if (req_rx_byte == '0) begin
                  phase_in = cfd_pkg::PH_EMIT;
               end else begin
                  phase_in = cfd_pkg::PH_PARAMS;
               end
            end
         end
         cfd_pkg::PH_PARAMS: begin
            if (req_take && params_done) begin
               phase_in = cfd_pkg::PH_EMIT;
            end
         end
         cfd_pkg::PH_EMIT: begin
            if (emit_load && emit_last) begin
               phase_in = cfd_pkg::PH_HUNT;
            end
         end
         default: phase_in = cfd_pkg::PH_HUNT;
      endcase
   end

   // datapath and response register
   always_comb begin
      held_opcode_in    = held_opcode_ff;
      held_length_in    = held_length_ff;
      param_count_in    = param_count_ff;
      step_in           = step_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_frame_byte_in = rsp_frame_byte_ff;
      rsp_frame_last_in = rsp_frame_last_ff;
      rsp_too_long_in   = rsp_too_long_ff;
      unique case (phase_ff)
         cfd_pkg::PH_HUNT: begin
         end
         cfd_pkg::PH_OPCODE: begin
            if (req_take) begin
               held_opcode_in = req_rx_byte;
            end
         end
         cfd_pkg::PH_LENGTH: begin
            if (req_take) begin
               held_length_in = req_rx_byte;
               param_count_in = '0;
               step_in        = '0;
               if (too_long_len) begin
                  rsp_valid_in      = 1'b1;
                  rsp_frame_byte_in = '0;
                  rsp_frame_last_in = 1'b0;
                  rsp_too_long_in   = 1'b1;
               end
            end
         end
         cfd_pkg::PH_PARAMS: begin
            if (req_take) begin
               param_count_in = param_count_ff + cfd_pkg::PARAM_CNT_W'(1);
            end
         end
         cfd_pkg::PH_EMIT: begin
            if (emit_load) begin
               step_in           = step_ff + cfd_pkg::STEP_W'(1);
               rsp_valid_in      = 1'b1;
               rsp_frame_last_in = emit_last;
               rsp_too_long_in   = 1'b0;
               priority if (step_ff == '0) begin
                  rsp_frame_byte_in = held_opcode_ff;
               end else if (step_ff == cfd_pkg::STEP_W'(1)) begin
                  rsp_frame_byte_in = held_length_ff;
               end else begin
                  rsp_frame_byte_in = rd_data_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= cfd_pkg::PH_HUNT;
         frame_prefix_ff <= '0;
         held_opcode_ff  <= '0;
         held_length_ff  <= '0;
         param_count_ff  <= '0;
         step_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         held_opcode_ff <= held_opcode_in;
         held_length_ff <= held_length_in;
         param_count_ff <= param_count_in;
         step_ff        <= step_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            frame_prefix_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_frame_byte_ff <= rsp_frame_byte_in;
      rsp_frame_last_ff <= rsp_frame_last_in;
      rsp_too_long_ff   <= rsp_too_long_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_frame_byte_ff;
   assign rsp_frame_last = rsp_frame_last_ff;
   assign rsp_too_long   = rsp_too_long_ff;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the command frame deframer. A fixed table of
// requests covers zero-length, over-length and full frames at the reset
// prefix; random frame traffic under several prefix settings follows, with
// random gaps on the request side and random stalls on the response side.
// Every response is compared field by field against the table or the parser mirror.
// ----------------------------------------------------------------------------
module testbench;

   localparam int IDLE_LIMIT   = 1000;
   localparam int PHASE_BUDGET = 60;

   typedef struct {
      cfd_pkg::byte_type data;
      logic              last;
      logic              too_long;
   } frame_result_type;

   typedef enum {ROW_MODEL, ROW_QUIET, ROW_ERROR, ROW_EMPTY} row_check_type;

   typedef struct {
      cfd_pkg::byte_type rx;
      row_check_type     chk;
      cfd_pkg::byte_type opcode;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   cfd_pkg::byte_type req_rx_byte = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   cfd_pkg::byte_type rsp_frame_byte;
   logic              rsp_frame_last;
   logic              rsp_too_long;
   logic              csr_wr_en = 1'b0;
   cfd_pkg::byte_type csr_wr_data = '0;

   // parser mirror
   cfd_pkg::phase_type parse_phase = cfd_pkg::PH_HUNT;
   cfd_pkg::byte_type  prefix_value = '0;
   cfd_pkg::byte_type  held_opcode = '0;
   cfd_pkg::byte_type  held_length = '0;
   int                 params_taken = 0;
   cfd_pkg::byte_type  param_bytes [cfd_pkg::MAX_PARAMS];
   frame_result_type   emitted [$];
   frame_result_type   frame_bytes_due [$];

   int failures = 0;
   int framed_requests = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   bit no_idle = 1'b0;

   stim_row_type directed_rows [0:25] = '{
      '{8'h00, ROW_QUIET, 8'h00},   // prefix at its reset value
      '{8'hFF, ROW_QUIET, 8'h00},
      '{8'h00, ROW_EMPTY, 8'hFF},   // zero length completes at once
      '{8'h5A, ROW_QUIET, 8'h00},   // not a prefix, ignored
      '{8'h00, ROW_QUIET, 8'h00},
      '{8'h00, ROW_QUIET, 8'h00},
      '{8'h11, ROW_ERROR, 8'h00},   // one more than the store holds
      '{8'h00, ROW_QUIET, 8'h00},
      '{8'hA5, ROW_QUIET, 8'h00},
      '{8'h10, ROW_QUIET, 8'h00},   // full store
      '{8'h00, ROW_QUIET, 8'h00},   // prefix value inside a frame is data
      '{8'hFF, ROW_QUIET, 8'h00},
      '{8'h01, ROW_QUIET, 8'h00},
      '{8'h80, ROW_QUIET, 8'h00},
      '{8'h7F, ROW_QUIET, 8'h00},
      '{8'hFE, ROW_QUIET, 8'h00},
      '{8'h00, ROW_QUIET, 8'h00},
      '{8'h55, ROW_QUIET, 8'h00},
      '{8'hAA, ROW_QUIET, 8'h00},
      '{8'h0F, ROW_QUIET, 8'h00},
      '{8'hF0, ROW_QUIET, 8'h00},
      '{8'h12, ROW_QUIET, 8'h00},
      '{8'h34, ROW_QUIET, 8'h00},
      '{8'h56, ROW_QUIET, 8'h00},
      '{8'h78, ROW_QUIET, 8'h00},
      '{8'h9A, ROW_MODEL, 8'h00}
   };

   command_frame_deframer uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_last (rsp_frame_last),
      .rsp_too_long   (rsp_too_long),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void replay_frame();
      emitted.push_back('{data: held_opcode, last: 1'b0, too_long: 1'b0});
      emitted.push_back('{data: held_length, last: held_length == 0, too_long: 1'b0});
      for (int i = 0; i < held_length && i < cfd_pkg::MAX_PARAMS; i++) begin
         emitted.push_back('{data: param_bytes[i], last: (i + 1) == held_length,
                             too_long: 1'b0});
      end
   endfunction

   // advances the parser mirror by one received byte, leaving its responses in emitted
   function automatic void parse_rx_byte(cfd_pkg::byte_type b);
      emitted.delete();
      case (parse_phase)
         cfd_pkg::PH_HUNT: begin
            if (b == prefix_value) parse_phase = cfd_pkg::PH_OPCODE;
         end
         cfd_pkg::PH_OPCODE: begin
            held_opcode = b;
            parse_phase = cfd_pkg::PH_LENGTH;
         end
         cfd_pkg::PH_LENGTH: begin
            held_length = b;
            params_taken = 0;
            if (b > cfd_pkg::MAX_PARAMS) begin
               emitted.push_back('{data: 8'h00, last: 1'b0, too_long: 1'b1});
               parse_phase = cfd_pkg::PH_HUNT;
            end else if (b == 0) begin
               replay_frame();
               parse_phase = cfd_pkg::PH_HUNT;
            end else begin
               parse_phase = cfd_pkg::PH_PARAMS;
            end
         end
         default: begin
            if (params_taken < cfd_pkg::MAX_PARAMS) param_bytes[params_taken] = b;
            params_taken++;
            if (params_taken >= held_length) begin
               replay_frame();
               params_taken = 0;
               parse_phase = cfd_pkg::PH_HUNT;
            end
         end
      endcase
   endfunction

   function automatic int request_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_request(input cfd_pkg::byte_type b);
      int gap;
      gap = request_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_tracked(input cfd_pkg::byte_type b);
      if (parse_phase != cfd_pkg::PH_HUNT || b == prefix_value) framed_requests++;
      send_request(b);
      parse_rx_byte(b);
      foreach (emitted[i]) frame_bytes_due.push_back(emitted[i]);
   endtask

   task automatic write_prefix(input cfd_pkg::byte_type value);
      req_valid <= 1'b0;
      while (frame_bytes_due.size() != 0) @(posedge clock);
      // let the replay sequencer settle before touching the register
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      prefix_value = value;
   endtask

   task automatic send_random_traffic(input int budget);
      int r;
      int len;
      framed_requests = 0;
      while (framed_requests < budget) begin
         r = $urandom_range(0, 99);
         if (r < 20) begin
            // noise and broken frames
            repeat ($urandom_range(1, 6)) send_tracked(cfd_pkg::byte_type'($urandom));
         end else begin
            r = $urandom_range(0, 99);
            if (r < 6) len = $urandom_range(18, 255);
            else if (r < 10) len = cfd_pkg::MAX_PARAMS + 1;
            else if (r < 16) len = cfd_pkg::MAX_PARAMS;
            else if (r < 26) len = 0;
            else len = $urandom_range(1, 6);
            send_tracked(prefix_value);
            send_tracked(cfd_pkg::byte_type'($urandom));
            send_tracked(cfd_pkg::byte_type'(len));
            if (len <= cfd_pkg::MAX_PARAMS) begin
               repeat (len) send_tracked(cfd_pkg::byte_type'($urandom));
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (no_idle) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
      end else begin : pick_stall
         int r;
         r = $urandom_range(0, 99);
         if (r < 60) begin
            rsp_ready <= 1'b1;
            stall_left = $urandom_range(1, 8);
         end else if (r < 90) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(1, 3);
         end else if (r < 96) begin
            rsp_ready <= 1'b1;
            stall_left = $urandom_range(30, 80);
         end else begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(20, 60);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      frame_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_bytes_due.size() == 0) begin
            $display("%0t: unexpected response byte %h last %b too_long %b", $time,
                     rsp_frame_byte, rsp_frame_last, rsp_too_long);
            failures++;
         end else begin
            want = frame_bytes_due.pop_front();
            if (rsp_frame_byte !== want.data) begin
               $display("%0t: frame_byte expected %h got %h", $time, want.data,
                        rsp_frame_byte);
               failures++;
            end
            if (rsp_frame_last !== want.last) begin
               $display("%0t: frame_last expected %b got %b", $time, want.last,
                        rsp_frame_last);
               failures++;
            end
            if (rsp_too_long !== want.too_long) begin
               $display("%0t: too_long expected %b got %b", $time, want.too_long,
                        rsp_too_long);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      cfd_pkg::byte_type next_prefix;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].rx);
         parse_rx_byte(directed_rows[i].rx);
         case (directed_rows[i].chk)
            ROW_MODEL: begin
               foreach (emitted[k]) frame_bytes_due.push_back(emitted[k]);
            end
            ROW_ERROR: begin
               frame_bytes_due.push_back('{data: 8'h00, last: 1'b0, too_long: 1'b1});
            end
            ROW_EMPTY: begin
               frame_bytes_due.push_back('{data: directed_rows[i].opcode, last: 1'b0,
                                           too_long: 1'b0});
               frame_bytes_due.push_back('{data: 8'h00, last: 1'b1, too_long: 1'b0});
            end
            default: begin
            end
         endcase
      end

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: next_prefix = 8'hFF;
            1: next_prefix = 8'h00;
            2: next_prefix = 8'h7E;
            default: next_prefix = cfd_pkg::byte_type'($urandom);
         endcase
         write_prefix(next_prefix);
         // one phase runs flat out on both sides
         no_idle = (ph == 2);
         send_random_traffic(PHASE_BUDGET);
      end
      req_valid <= 1'b0;
      no_idle = 1'b0;

      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/cfd_pkg.sv
hw/rtl/command_frame_deframer.sv
test/testbench.sv
